[rtl/pstb_pkg.sv]
// Shared widths, codes and control types of the panorama scroll tile binder.
package pstb_pkg;

   localparam int SUB_SHIFT = 4;
   localparam int CNT_W     = 7;
   localparam int WID_W     = 10;
   localparam int SPD_W     = 12;
   localparam int PAT_W     = 10;
   localparam int PF_W      = 16;
   localparam int OFF_W     = 21;
   localparam int SPAN_W    = WID_W + SUB_SHIFT;
   localparam int PER_W     = SPAN_W + CNT_W;
   localparam int PX_W      = PER_W - SUB_SHIFT;
   localparam int DVN_W     = OFF_W + 1;
   localparam int DCNT_W    = $clog2(DVN_W + 1);
   localparam int SLOT_W    = 8;
   localparam int ORG_W     = 11;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [SLOT_W-1:0] SLOT_EMPTY = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_AT_PX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_FRAMES = 3'd4;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      DSEL_WAS,
      DSEL_OFF,
      DSEL_NOW,
      DSEL_PX,
      DSEL_TILE
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DEC,
      ST_WAS_GO,
      ST_WAS_RUN,
      ST_OFF_GO,
      ST_OFF_RUN,
      ST_NOW_GO,
      ST_NOW_RUN,
      ST_TICK_FIN,
      ST_PX_GO,
      ST_PX_RUN,
      ST_TILE_GO,
      ST_TILE_RUN,
      ST_DRAW_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        clear_res;
      logic        div_start;
      logic        div_cap;
      div_sel_type div_sel;
      logic        pause_dec;
      logic        tick_commit;
      logic        draw_commit;
      logic        query_commit;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     pause_active;
      logic     pause_en;
      logic     div_done;
      logic     out_free;
   } stat_type;

endpackage

[rtl/panorama_scroll_tile_binder_unit.sv]
// Scroll engine for a wrapping tiled panorama: top level.
//
// Requests come in on req_ (valid/stall): kind 0 advances the scroll one tick,
// kind 1 binds the visible left/right tiles to the two slots, kind 2 returns
// the forward distance to req_target_offset. Each request gives one result on
// rsp_ (valid/stall), carrying the offset and stall flag after the step. The
// user writes registers on csr_ one per cycle, only while idle; not enforced.
//
// One request is worked at a time; req_stall is high from the cycle after a
// transfer until the result is in the output register. The shared 22-step
// restoring divider does all divisions: three for a tick with pausing enabled,
// two without, none while counting a pause down; two for a draw and none
// for a query or an unknown kind. The output register lets the result wait
// under rsp_stall; the next request can transfer in the cycle after the
// previous result has been loaded into it.
// Reset (synchronous) puts the registers at their defaults, the offset and
// pause count at zero and both slots empty; it takes effect at once.
module panorama_scroll_tile_binder_unit
   import pstb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [OFF_W-1:0]        req_target_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OFF_W-1:0]        rsp_offset_now,
   output logic                    rsp_stalled,
   output logic [CNT_W-1:0]        rsp_first_tile,
   output logic [CNT_W-1:0]        rsp_next_tile,
   output logic signed [ORG_W-1:0] rsp_origin_x,
   output logic                    rsp_left_slot,
   output logic                    rsp_right_slot,
   output logic                    rsp_refill_slot0,
   output logic [CNT_W-1:0]        rsp_refill_tile0,
   output logic                    rsp_refill_slot1,
   output logic [CNT_W-1:0]        rsp_refill_tile1,
   output logic [OFF_W-1:0]        rsp_distance,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DAT_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   pstb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pstb_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_kind),
      .req_target_offset (req_target_offset),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_offset_now    (rsp_offset_now),
      .rsp_stalled       (rsp_stalled),
      .rsp_first_tile    (rsp_first_tile),
      .rsp_next_tile     (rsp_next_tile),
      .rsp_origin_x      (rsp_origin_x),
      .rsp_left_slot     (rsp_left_slot),
      .rsp_right_slot    (rsp_right_slot),
      .rsp_refill_slot0  (rsp_refill_slot0),
      .rsp_refill_tile0  (rsp_refill_tile0),
      .rsp_refill_slot1  (rsp_refill_slot1),
      .rsp_refill_tile1  (rsp_refill_tile1),
      .rsp_distance      (rsp_distance)
   );

endmodule

[rtl/pstb_div.sv]
// Restoring divider, one quotient bit per cycle.
module pstb_div
   import pstb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVN_W-1:0] dividend,
   input  logic [PER_W-1:0] divisor,
   output logic [DVN_W-1:0] quot,
   output logic [PER_W-1:0] rem,
   output logic             done
);

   logic [DVN_W-1:0]  quot_ff, quot_in;
   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [PER_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, quot_ff[DVN_W-1]};
   assign ge    = trial >= {1'b0, divisor};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = DCNT_W'(DVN_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? PER_W'(trial - {1'b0, divisor}) : PER_W'(trial);
         quot_in = {quot_ff[DVN_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

[rtl/pstb_datapath.sv]
// Datapath: config registers, scroll state, slot binding and result registers.
module pstb_datapath
   import pstb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DAT_W-1:0]    csr_wdata,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [OFF_W-1:0]        req_target_offset,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [OFF_W-1:0]        rsp_offset_now,
   output logic                    rsp_stalled,
   output logic [CNT_W-1:0]        rsp_first_tile,
   output logic [CNT_W-1:0]        rsp_next_tile,
   output logic signed [ORG_W-1:0] rsp_origin_x,
   output logic                    rsp_left_slot,
   output logic                    rsp_right_slot,
   output logic                    rsp_refill_slot0,
   output logic [CNT_W-1:0]        rsp_refill_tile0,
   output logic                    rsp_refill_slot1,
   output logic [CNT_W-1:0]        rsp_refill_tile1,
   output logic [OFF_W-1:0]        rsp_distance
);

   // configuration
   logic [CNT_W-1:0] tile_count_ff;
   logic [WID_W-1:0] tile_width_ff;
   logic [SPD_W-1:0] scroll_speed_ff;
   logic [PAT_W-1:0] pause_at_ff;
   logic [PF_W-1:0]  pause_frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_count_ff   <= CNT_W'(1);
         tile_width_ff   <= WID_W'(144);
         scroll_speed_ff <= '0;
         pause_at_ff     <= '0;
         pause_frames_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TILE_COUNT:   tile_count_ff   <= csr_wdata[CNT_W-1:0];
            CSR_TILE_WIDTH:   tile_width_ff   <= csr_wdata[WID_W-1:0];
            CSR_SCROLL_SPEED: scroll_speed_ff <= csr_wdata[SPD_W-1:0];
            CSR_PAUSE_AT_PX:  pause_at_ff     <= csr_wdata[PAT_W-1:0];
            CSR_PAUSE_FRAMES: pause_frames_ff <= csr_wdata[PF_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0]  eff_n;
   logic [WID_W-1:0]  eff_w;
   logic [SPAN_W-1:0] span, pat;
   logic [PER_W-1:0]  period_ff;

   assign eff_n = (tile_count_ff == '0) ? CNT_W'(1) : tile_count_ff;
   assign eff_w = (tile_width_ff == '0) ? WID_W'(1) : tile_width_ff;
   assign span  = SPAN_W'(eff_w) << SUB_SHIFT;
   assign pat   = SPAN_W'(pause_at_ff) << SUB_SHIFT;

   // period follows config through a register; never read in the accept cycle
   always_ff @(posedge clock) begin
      period_ff <= PER_W'(span) * PER_W'(eff_n);
   end

   // request capture and scroll state
   kind_type         kind_ff;
   logic [OFF_W-1:0] target_ff;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [PF_W-1:0]  pause_left_ff, pause_left_in;

   logic [SPAN_W-1:0] was_ff, now_ff;
   logic [PER_W-1:0]  off_ff;
   logic [PX_W-1:0]   px_ff;
   logic [CNT_W-1:0]  left_ff;
   logic [WID_W-1:0]  inpx_ff;

   // divider and its operands
   logic [DVN_W-1:0] dvn, quot;
   logic [PER_W-1:0] dvs, rem;
   logic             div_done;

   always_comb begin
      case (cmd.div_sel)
         DSEL_OFF: begin
            dvn = DVN_W'(offset_ff) + DVN_W'(scroll_speed_ff);
            dvs = period_ff;
         end
         DSEL_NOW: begin
            dvn = DVN_W'(off_ff);
            dvs = PER_W'(span);
         end
         DSEL_PX: begin
            dvn = DVN_W'(offset_ff >> SUB_SHIFT);
            dvs = period_ff >> SUB_SHIFT;
         end
         DSEL_TILE: begin
            dvn = DVN_W'(px_ff);
            dvs = PER_W'(eff_w);
         end
         default: begin
            dvn = DVN_W'(offset_ff);
            dvs = PER_W'(span);
         end
      endcase
   end

   pstb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvn),
      .divisor  (dvs),
      .quot     (quot),
      .rem      (rem),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_cap) begin
         case (cmd.div_sel)
            DSEL_WAS: was_ff <= SPAN_W'(rem);
            DSEL_OFF: off_ff <= rem;
            DSEL_NOW: now_ff <= SPAN_W'(rem);
            DSEL_PX:  px_ff  <= PX_W'(rem);
            DSEL_TILE: begin
               left_ff <= CNT_W'(quot);
               inpx_ff <= WID_W'(rem);
            end
            default: ;
         endcase
      end
   end

   logic snap;
   assign snap = (pause_frames_ff != '0) && (was_ff < pat) && (now_ff >= pat);

   always_comb begin
      offset_in     = offset_ff;
      pause_left_in = pause_left_ff;
      if (cmd.pause_dec) begin
         pause_left_in = pause_left_ff - 1'b1;
      end else if (cmd.tick_commit) begin
         if (snap) begin
            offset_in     = OFF_W'(off_ff - PER_W'(now_ff - pat));
            pause_left_in = pause_frames_ff;
         end else begin
            offset_in = OFF_W'(off_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= kind_type'(req_kind);
         target_ff <= req_target_offset;
      end
      if (reset) begin
         offset_ff     <= '0;
         pause_left_ff <= '0;
      end else begin
         offset_ff     <= offset_in;
         pause_left_ff <= pause_left_in;
      end
   end

   // slot binding
   logic [SLOT_W-1:0] holds_ff [2];
   logic [SLOT_W-1:0] holds_in [2];
   logic [CNT_W-1:0]  right_c;
   logic [SLOT_W-1:0] lx, rx;
   logic              b_ls, b_rs, b_r0, b_r1;
   logic [CNT_W-1:0]  b_t0, b_t1;

   assign right_c = ((CNT_W + 1)'(left_ff) + 1'b1 == (CNT_W + 1)'(eff_n)) ?
                    '0 : CNT_W'(left_ff + 1'b1);
   assign lx = SLOT_W'(left_ff);
   assign rx = SLOT_W'(right_c);

   always_comb begin
      logic tk0, tk1, bd0, bd1;
      tk0 = 1'b0;
      tk1 = 1'b0;
      bd0 = 1'b0;
      bd1 = 1'b0;
      b_ls = 1'b0;
      b_rs = 1'b0;
      b_r0 = 1'b0;
      b_r1 = 1'b0;
      b_t0 = '0;
      b_t1 = '0;
      holds_in[0] = holds_ff[0];
      holds_in[1] = holds_ff[1];
      if (left_ff == right_c) begin
         if (holds_ff[0] == lx) begin
            b_ls = 1'b0;
            b_rs = 1'b0;
         end else if (holds_ff[1] == lx) begin
            b_ls = 1'b1;
            b_rs = 1'b1;
         end else begin
            holds_in[0] = lx;
            b_r0 = 1'b1;
            b_t0 = left_ff;
         end
      end else begin
         // reuse held tiles first
         if (holds_ff[0] == lx) begin
            tk0 = 1'b1;
            bd0 = 1'b1;
            b_ls = 1'b0;
         end else if (holds_ff[1] == lx) begin
            tk1 = 1'b1;
            bd0 = 1'b1;
            b_ls = 1'b1;
         end
         if (!tk0 && holds_ff[0] == rx) begin
            tk0 = 1'b1;
            bd1 = 1'b1;
            b_rs = 1'b0;
         end else if (!tk1 && holds_ff[1] == rx) begin
            tk1 = 1'b1;
            bd1 = 1'b1;
            b_rs = 1'b1;
         end
         // refill the first free slot for each tile still unbound
         if (!bd0) begin
            if (tk0) begin
               tk1 = 1'b1;
               b_ls = 1'b1;
               holds_in[1] = lx;
               b_r1 = 1'b1;
               b_t1 = left_ff;
            end else begin
               tk0 = 1'b1;
               b_ls = 1'b0;
               holds_in[0] = lx;
               b_r0 = 1'b1;
               b_t0 = left_ff;
            end
         end
         if (!bd1) begin
            if (tk0) begin
               b_rs = 1'b1;
               holds_in[1] = rx;
               b_r1 = 1'b1;
               b_t1 = right_c;
            end else begin
               b_rs = 1'b0;
               holds_in[0] = rx;
               b_r0 = 1'b1;
               b_t0 = right_c;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holds_ff[0] <= SLOT_EMPTY;
         holds_ff[1] <= SLOT_EMPTY;
      end else if (cmd.draw_commit) begin
         holds_ff[0] <= holds_in[0];
         holds_ff[1] <= holds_in[1];
      end
   end

   // distance query
   logic [OFF_W:0] diff, fwd_dist;
   assign diff     = {1'b0, target_ff} - {1'b0, offset_ff};
   assign fwd_dist = diff[OFF_W] ? diff + (OFF_W + 1)'(period_ff) : diff;

   // pending result
   logic [CNT_W-1:0]        res_left, res_right, res_t0, res_t1;
   logic signed [ORG_W-1:0] res_org;
   logic                    res_ls, res_rs, res_r0, res_r1;
   logic [OFF_W-1:0]        res_dist;

   always_ff @(posedge clock) begin
      if (cmd.clear_res) begin
         res_left  <= '0;
         res_right <= '0;
         res_org   <= '0;
         res_ls    <= 1'b0;
         res_rs    <= 1'b0;
         res_r0    <= 1'b0;
         res_t0    <= '0;
         res_r1    <= 1'b0;
         res_t1    <= '0;
         res_dist  <= cmd.query_commit ? fwd_dist[OFF_W-1:0] : '0;
      end else if (cmd.draw_commit) begin
         res_left  <= left_ff;
         res_right <= right_c;
         res_org   <= ORG_W'(-{1'b0, inpx_ff});
         res_ls    <= b_ls;
         res_rs    <= b_rs;
         res_r0    <= b_r0;
         res_t0    <= b_t0;
         res_r1    <= b_r1;
         res_t1    <= b_t1;
      end
   end

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_offset_now   <= offset_ff;
         rsp_stalled      <= (pause_left_ff != '0);
         rsp_first_tile   <= res_left;
         rsp_next_tile    <= res_right;
         rsp_origin_x     <= res_org;
         rsp_left_slot    <= res_ls;
         rsp_right_slot   <= res_rs;
         rsp_refill_slot0 <= res_r0;
         rsp_refill_tile0 <= res_t0;
         rsp_refill_slot1 <= res_r1;
         rsp_refill_tile1 <= res_t1;
         rsp_distance     <= res_dist;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign stat.kind         = kind_ff;
   assign stat.pause_active = (pause_left_ff != '0);
   assign stat.pause_en     = (pause_frames_ff != '0);
   assign stat.div_done     = div_done;
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;

endmodule

[rtl/pstb_ctrl.sv]
// Sequencing state machine: steps one request through the datapath.
module pstb_ctrl
   import pstb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (stat.kind)
               KIND_TICK:  state_in = stat.pause_active ? ST_DEC : ST_WAS_GO;
               KIND_DRAW:  state_in = ST_PX_GO;
               default:    state_in = ST_EMIT;
            endcase
         end
         ST_DEC:      state_in = ST_EMIT;
         ST_WAS_GO:   state_in = ST_WAS_RUN;
         ST_WAS_RUN:  if (stat.div_done) state_in = ST_OFF_GO;
         ST_OFF_GO:   state_in = ST_OFF_RUN;
         ST_OFF_RUN: begin
            if (stat.div_done) state_in = stat.pause_en ? ST_NOW_GO : ST_TICK_FIN;
         end
         ST_NOW_GO:   state_in = ST_NOW_RUN;
         ST_NOW_RUN:  if (stat.div_done) state_in = ST_TICK_FIN;
         ST_TICK_FIN: state_in = ST_EMIT;
         ST_PX_GO:    state_in = ST_PX_RUN;
         ST_PX_RUN:   if (stat.div_done) state_in = ST_TILE_GO;
         ST_TILE_GO:  state_in = ST_TILE_RUN;
         ST_TILE_RUN: if (stat.div_done) state_in = ST_DRAW_FIN;
         ST_DRAW_FIN: state_in = ST_EMIT;
         ST_EMIT:     if (stat.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = DSEL_WAS;
      case (state_ff)
         ST_IDLE:     cmd.accept = req_valid;
         ST_DISPATCH: begin
            // a query result is formed while the others are cleared
            cmd.clear_res    = 1'b1;
            cmd.query_commit = (stat.kind == KIND_QUERY);
         end
         ST_DEC:      cmd.pause_dec = 1'b1;
         ST_WAS_GO:   cmd.div_start = 1'b1;
         ST_WAS_RUN:  cmd.div_cap = stat.div_done;
         ST_OFF_GO: begin
            cmd.div_sel   = DSEL_OFF;
            cmd.div_start = 1'b1;
         end
         ST_OFF_RUN: begin
            cmd.div_sel = DSEL_OFF;
            cmd.div_cap = stat.div_done;
         end
         ST_NOW_GO: begin
            cmd.div_sel   = DSEL_NOW;
            cmd.div_start = 1'b1;
         end
         ST_NOW_RUN: begin
            cmd.div_sel = DSEL_NOW;
            cmd.div_cap = stat.div_done;
         end
         ST_TICK_FIN: cmd.tick_commit = 1'b1;
         ST_PX_GO: begin
            cmd.div_sel   = DSEL_PX;
            cmd.div_start = 1'b1;
         end
         ST_PX_RUN: begin
            cmd.div_sel = DSEL_PX;
            cmd.div_cap = stat.div_done;
         end
         ST_TILE_GO: begin
            cmd.div_sel   = DSEL_TILE;
            cmd.div_start = 1'b1;
         end
         ST_TILE_RUN: begin
            cmd.div_sel = DSEL_TILE;
            cmd.div_cap = stat.div_done;
         end
         ST_DRAW_FIN: cmd.draw_commit = 1'b1;
         ST_EMIT:     cmd.load_rsp = stat.out_free;
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[rtl/pstb_checker.sv]
// Port-level checks of the scroll tile binder, bound to the top level.
module pstb_checker
   import pstb_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [OFF_W-1:0]        rsp_offset_now,
   input logic [CNT_W-1:0]        rsp_first_tile,
   input logic [CNT_W-1:0]        rsp_next_tile,
   input logic signed [ORG_W-1:0] rsp_origin_x,
   input logic                    rsp_left_slot,
   input logic                    rsp_right_slot,
   input logic                    rsp_refill_slot0,
   input logic [CNT_W-1:0]        rsp_refill_tile0,
   input logic                    rsp_refill_slot1,
   input logic [CNT_W-1:0]        rsp_refill_tile1,
   input logic [OFF_W-1:0]        rsp_distance
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_offset_now)
         && $stable(rsp_distance) && $stable(rsp_first_tile))
      else $error("stalled result changed");

   // one request in flight: no transfer right after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // distinct tiles never share a slot
   a_slots_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_first_tile != rsp_next_tile) |->
         (rsp_left_slot != rsp_right_slot))
      else $error("two tiles bound to one slot");

   // no refill tile without a refill, and the origin never lies right of zero
   a_refill_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_refill_slot0 || rsp_refill_tile0 == '0)
         && (rsp_refill_slot1 || rsp_refill_tile1 == '0) && !(rsp_origin_x > 0))
      else $error("bad bind fields");

endmodule

bind panorama_scroll_tile_binder_unit pstb_checker u_pstb_checker (.*);
